/* sv/mtu_pkg.sv */
// shared types, constants and helpers for the mac to uuid v5 core
package mtu_pkg;

	typedef logic [31:0] word_t;

	localparam int UUID_CHARS = 36;
	localparam int ROUNDS = 80;

	localparam word_t H0 = 32'h67452301;
	localparam word_t H1 = 32'hEFCDAB89;
	localparam word_t H2 = 32'h98BADCFE;
	localparam word_t H3 = 32'h10325476;
	localparam word_t H4 = 32'hC3D2E1F0;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	// dns namespace uuid 6ba7b810-9dad-11d1-80b4-00c04fd430c8
	localparam logic [127:0] DNS_SPACE = 128'h6ba7b8109dad11d180b400c04fd430c8;

	// padding word after the 28-byte name and the length word (224 bits)
	localparam word_t PAD_WORD = 32'h80000000;
	localparam word_t LEN_WORD = 32'h000000E0;

	localparam logic [6:0] CHAR_DASH = 7'h2D;
	localparam logic [3:0] UUID_VERSION = 4'h5;
	localparam logic [1:0] UUID_VARIANT = 2'b10;

	// sequencer states of the top level
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HASH = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	typedef struct packed {
		logic       valid;
		logic [6:0] ch;
		logic       last;
	} txt_out_t;

	function automatic logic [6:0] hex_lower(input logic [3:0] nib);
		logic [6:0] v;
		v = {3'b000, nib};
		if (nib < 4'd10) begin
			hex_lower = 7'h30 + v;
		end else begin
			hex_lower = 7'h57 + v;
		end
	endfunction

	function automatic word_t rotl(input word_t x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

/* sv/mtu_sha1.sv */
// single-block sha-1 engine, one round per cycle on a shared round unit
module mtu_sha1 import mtu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] blk,
	output logic         done,
	output logic [127:0] digest
);

	word_t       a_q, b_q, c_q, d_q, e_q;
	word_t       w_q [16];
	logic [6:0]  rnd_q;
	logic        run_q;
	logic        fin_q;
	logic        done_q;
	logic [127:0] digest_q;

	word_t f;
	word_t k;
	word_t tmp;
	word_t w_new;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		tmp = rotl(a_q, 5) + f + e_q + k + w_q[0];
		w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(ROUNDS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= H0;
			b_q <= H1;
			c_q <= H2;
			d_q <= H3;
			e_q <= H4;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[511 - 32 * i -: 32];
			end
		end else if (run_q) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (fin_q) begin
			digest_q <= {a_q + H0, b_q + H1, c_q + H2, d_q + H3};
		end
	end

	assign done   = done_q;
	assign digest = digest_q;

endmodule

/* sv/mtu_text.sv */
// formats a 128-bit uuid as 36 characters: 32 lowercase hex digits and four dashes
module mtu_text import mtu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] uuid,
	output txt_out_t     txt
);

	logic [127:0] sh_q;
	logic [5:0]   pos_q;
	logic         act_q;
	logic         valid_q;
	logic [6:0]   ch_q;
	logic         last_q;
	logic         dash;

	always_comb begin
		dash = pos_q inside {6'd8, 6'd13, 6'd18, 6'd23};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= act_q;
			if (start) begin
				act_q <= 1'b1;
				pos_q <= '0;
			end else if (act_q) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'(UUID_CHARS - 1)) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= uuid;
		end else if (act_q && !dash) begin
			sh_q <= {sh_q[123:0], 4'h0};
		end
		ch_q   <= dash ? CHAR_DASH : hex_lower(sh_q[127:124]);
		last_q <= (pos_q == 6'(UUID_CHARS - 1));
	end

	assign txt = {valid_q, ch_q, last_q};

endmodule

/* sv/mac_to_uuid_v5_core.sv */
// top level: mac address in, name-based version 5 uuid text out
//
// a word is accepted on a rising edge with start high and busy low; the
// 48-bit mac_address is sampled there, first byte in bits 47..40
// busy stays high from that edge until the last character has been shown
// the block hashes the dns namespace uuid followed by the mac as 12 hex
// digits with sha-1, one round per cycle on a single round unit, then
// registers the final additions and sets the version/variant bits
// the uuid text then comes out as 36 words, one per cycle, each marked by
// valid for exactly one cycle; last_char is high on the final one
// the first character follows the registered digest through the text
// formatter; a new word can be taken only once busy has fallen after the
// last character of the previous one
// the receiver cannot stall the output: every valid word is taken as shown
// reset clears the sequencer and valid, not last_char; in-flight items drop
module mac_to_uuid_v5_core import mtu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [47:0] mac_address,
	output logic        valid,
	output logic [6:0]  text_char,
	output logic        last_char
);

	logic [1:0]   state_q;
	logic [95:0]  mac_txt;
	logic [511:0] blk;
	logic         accept;
	logic         sha_done;
	logic [127:0] digest;
	logic [127:0] uuid;
	txt_out_t     txt;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		for (int j = 0; j < 12; j++) begin
			mac_txt[95 - 8 * j -: 8] = {1'b0, hex_lower(mac_address[47 - 4 * j -: 4])};
		end
		blk = {DNS_SPACE, mac_txt, PAD_WORD, 224'b0, LEN_WORD};
	end

	mtu_sha1 u_sha1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.blk    (blk),
		.done   (sha_done),
		.digest (digest)
	);

	// version nibble in byte 6, variant bits in byte 8
	always_comb begin
		uuid = digest;
		uuid[79:76] = UUID_VERSION;
		uuid[63:62] = UUID_VARIANT;
	end

	mtu_text u_text (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_done),
		.uuid   (uuid),
		.txt    (txt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (sha_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (txt.valid && txt.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign valid     = txt.valid;
	assign text_char = txt.ch;
	assign last_char = txt.last;

endmodule
